// ===== hw/rtl/ime_pkg.sv =====
package ime_pkg;

    // Operation codes carried by a command transaction.
    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_RESTART = 2'd2,
        OP_STEP    = 2'd3
    } ime_op_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_AXIS,
        ST_MEM
    } ime_state_t;

    // Configuration register indexes (byte address is 8 times the index).
    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_AXES     = 3'd1;
    localparam logic [2:0] REG_CHANNELS = 3'd2;
    localparam logic [2:0] REG_GEO0     = 3'd3;
    localparam logic [2:0] REG_GEO1     = 3'd4;
    localparam logic [2:0] REG_GEO2     = 3'd5;

    localparam int NUM_GEO = 3;
    localparam logic [39:0] GEO_RESET = 40'h11_0100_1001;

    // One queued command.
    typedef struct packed {
        ime_op_t     op;
        logic [15:0] addr;
        logic [31:0] data;
    } ime_item_t;

    // Configuration seen by the back end.
    typedef struct packed {
        logic                    mode_im2col;
        logic [1:0]              axis_count;
        logic [11:0]             column_channels;
        logic [NUM_GEO-1:0][39:0] geometry;
    } ime_cfg_t;

endpackage

// ===== hw/rtl/ime_cmd_if.sv =====
interface ime_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [15:0]        address;
    logic signed [31:0] data_in;

    modport source (output valid, output opcode, output address, output data_in, input ready);
    modport sink (input valid, input opcode, input address, input data_in, output ready);
endinterface

// ===== hw/rtl/ime_rsp_if.sv =====
interface ime_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_data;
    logic [15:0]        image_index;
    logic [23:0]        column_index;
    logic               in_padding;
    logic               walk_done;

    modport source (output valid, output out_data, output image_index, output column_index,
                    output in_padding, output walk_done, input ready);
    modport sink (input valid, input out_data, input image_index, input column_index,
                  input in_padding, input walk_done, output ready);
endinterface

// ===== hw/rtl/ime_ram.sv =====
module ime_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== hw/rtl/ime_front.sv =====
module ime_front (
    input  logic            clk,
    input  logic            rst_n,
    ime_cmd_if.sink         cmd,
    output logic            q_valid,
    output ime_pkg::ime_item_t q_item,
    input  logic            q_pop
);
    import ime_pkg::*;

    ime_item_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    ime_item_t  item_in;

    // Classify the incoming transaction into a queue entry.
    always_comb
    begin
        item_in.op   = ime_op_t'(cmd.opcode);
        item_in.addr = cmd.address;
        item_in.data = cmd.data_in;
    end

    assign cmd.ready = (count_reg != 2'd2);
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (count_reg != 2'd0);
    assign q_item    = slot_reg[rd_ptr_reg];

    // Queue pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end
endmodule

// ===== hw/rtl/ime_back.sv =====
module ime_back #(
    parameter int IMAGE_DEPTH = 65536,
    parameter int MAX_AXES    = 3,
    parameter int DATA_WIDTH  = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ime_pkg::ime_cfg_t  cfg,
    input  logic               q_valid,
    input  ime_pkg::ime_item_t q_item,
    output logic               q_pop,
    ime_rsp_if.source          rsp
);
    import ime_pkg::*;

    localparam int ADDR_W = $clog2(IMAGE_DEPTH);
    localparam logic [1:0] MAX_N = 2'(MAX_AXES);

    ime_state_t state_reg, state_next;

    ime_op_t                 op_reg, op_next;
    logic [ADDR_W-1:0]       addr_reg, addr_next;
    logic [DATA_WIDTH-1:0]   data_reg, data_next;
    logic [11:0]             cc_reg, cc_next;
    logic [NUM_GEO-1:0][11:0] opos_reg, opos_next;
    logic [NUM_GEO-1:0][3:0] koff_reg, koff_next;
    logic [1:0]              ax_reg, ax_next;
    logic [3:0]              bit_reg, bit_next;
    logic [3:0]              rem_reg, rem_next;
    logic [11:0]             dq_reg, dq_next;
    logic [23:0]             idxc_reg, idxc_next;
    logic [ADDR_W-1:0]       idxi_reg, idxi_next;
    logic                    pad_reg, pad_next;

    logic                    res_valid_reg, res_valid_next;
    logic [31:0]             res_data_reg, res_data_next;
    logic [15:0]             res_im_reg, res_im_next;
    logic [23:0]             res_col_reg, res_col_next;
    logic                    res_pad_reg, res_pad_next;
    logic                    res_done_reg, res_done_next;

    logic                    ram_we, ram_re;
    logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0]   ram_wdata, ram_rdata;

    logic [1:0]              nax, last_ax;
    logic [11:0]             chans;
    logic [39:0]             geo_cur;
    logic [3:0]              kext_cur;
    logic [11:0]             oext_cur, iext_cur;
    logic [4:0]              trial, diff;
    logic                    ge;
    logic [15:0]             os_prod;
    logic [7:0]              kd_prod;
    logic signed [17:0]      pos;
    logic [17:0]             pos_u;
    logic                    pad_new;
    logic [23:0]             idxc_new;
    logic [ADDR_W-1:0]       idxi_new;
    logic [NUM_GEO-1:0][11:0] opos_adv;
    logic                    walk_last;
    logic                    walk_end;
    logic [DATA_WIDTH-1:0]   word_sum;

    ime_ram #(.WIDTH(DATA_WIDTH), .DEPTH(IMAGE_DEPTH)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Effective axis count and channel count.
    always_comb
    begin
        if (cfg.axis_count == 2'd0)
        begin
            nax = 2'd1;
        end
        else if (cfg.axis_count > MAX_N)
        begin
            nax = MAX_N;
        end
        else
        begin
            nax = cfg.axis_count;
        end
        last_ax = nax - 2'd1;
        chans   = (cfg.column_channels == 12'd0) ? 12'd1 : cfg.column_channels;
    end

    // Geometry of the axis under work.
    always_comb
    begin
        geo_cur  = cfg.geometry[ax_reg];
        kext_cur = (geo_cur[27:24] == 4'd0) ? 4'd1 : geo_cur[27:24];
        oext_cur = (geo_cur[23:12] == 12'd0) ? 12'd1 : geo_cur[23:12];
        iext_cur = geo_cur[11:0];
    end

    // One restoring division step: the kernel offset is the remainder.
    always_comb
    begin
        trial = {rem_reg, dq_reg[11]};
        ge    = (trial >= {1'b0, kext_cur});
        diff  = trial - {1'b0, kext_cur};
    end

    // Image position along the current axis and the running indexes.
    always_comb
    begin
        os_prod  = opos_reg[ax_reg] * geo_cur[35:32];
        kd_prod  = koff_reg[ax_reg] * geo_cur[39:36];
        pos      = $signed({2'b00, os_prod}) + $signed({10'd0, kd_prod})
                 - $signed({14'd0, geo_cur[31:28]});
        pos_u    = pos;
        pad_new  = pad_reg || pos[17] || (pos >= $signed({6'd0, iext_cur}));
        idxc_new = 24'(idxc_reg * oext_cur) + 24'(opos_reg[ax_reg]);
        idxi_new = ADDR_W'(idxi_reg * iext_cur) + (pad_new ? '0 : ADDR_W'(pos_u));
    end

    // Odometer advance over the output positions, last axis fastest.
    always_comb
    begin
        logic carry;
        logic [11:0] oe;
        carry    = 1'b1;
        opos_adv = opos_reg;
        for (int d = NUM_GEO - 1; d >= 0; d--)
        begin
            oe = (cfg.geometry[d][23:12] == 12'd0) ? 12'd1 : cfg.geometry[d][23:12];
            if ((2'(d) < nax) && carry)
            begin
                if (opos_reg[d] >= oe - 12'd1)
                begin
                    opos_adv[d] = 12'd0;
                end
                else
                begin
                    opos_adv[d] = opos_reg[d] + 12'd1;
                    carry       = 1'b0;
                end
            end
        end
        walk_last = carry;
        walk_end  = carry && (cc_reg >= chans - 12'd1);
    end

    assign word_sum = ram_rdata + data_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && !res_valid_reg)
                begin
                    unique case (q_item.op)
                        OP_READ:  state_next = ST_MEM;
                        OP_STEP:  state_next = ST_DIV;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV:
            begin
                if ((bit_reg == 4'd11) && (ax_reg == 2'd0))
                begin
                    state_next = ST_AXIS;
                end
            end
            ST_AXIS:
            begin
                if (ax_reg == last_ax)
                begin
                    state_next = pad_new ? ST_IDLE : ST_MEM;
                end
            end
            ST_MEM:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, walk counters, memory controls and result register.
    always_comb
    begin
        op_next        = op_reg;
        addr_next      = addr_reg;
        data_next      = data_reg;
        cc_next        = cc_reg;
        opos_next      = opos_reg;
        koff_next      = koff_reg;
        ax_next        = ax_reg;
        bit_next       = bit_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        idxc_next      = idxc_reg;
        idxi_next      = idxi_reg;
        pad_next       = pad_reg;
        res_valid_next = res_valid_reg && !rsp.ready;
        res_data_next  = res_data_reg;
        res_im_next    = res_im_reg;
        res_col_next   = res_col_reg;
        res_pad_next   = res_pad_reg;
        res_done_next  = res_done_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = ADDR_W'(q_item.addr);
        ram_wdata      = DATA_WIDTH'($signed(q_item.data));
        ram_re         = 1'b0;
        ram_raddr      = ADDR_W'(q_item.addr);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && !res_valid_reg)
                begin
                    q_pop     = 1'b1;
                    op_next   = q_item.op;
                    addr_next = ADDR_W'(q_item.addr);
                    data_next = DATA_WIDTH'($signed(q_item.data));
                    unique case (q_item.op)
                        OP_WRITE:
                        begin
                            ram_we         = 1'b1;
                            res_valid_next = 1'b1;
                            res_data_next  = 32'(ram_wdata);
                            res_im_next    = 16'(ADDR_W'(q_item.addr));
                            res_col_next   = 24'd0;
                            res_pad_next   = 1'b0;
                            res_done_next  = 1'b0;
                        end
                        OP_READ:
                        begin
                            ram_re = 1'b1;
                        end
                        OP_RESTART:
                        begin
                            cc_next        = 12'd0;
                            opos_next      = '0;
                            koff_next      = '0;
                            res_valid_next = 1'b1;
                            res_data_next  = 32'd0;
                            res_im_next    = 16'd0;
                            res_col_next   = 24'd0;
                            res_pad_next   = 1'b0;
                            res_done_next  = 1'b0;
                        end
                        OP_STEP:
                        begin
                            ax_next  = last_ax;
                            bit_next = 4'd0;
                            rem_next = 4'd0;
                            dq_next  = cc_reg;
                        end
                        default:
                        begin
                            op_next = q_item.op;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                rem_next = ge ? diff[3:0] : trial[3:0];
                dq_next  = {dq_reg[10:0], ge};
                bit_next = bit_reg + 4'd1;
                if (bit_reg == 4'd11)
                begin
                    koff_next[ax_reg] = ge ? diff[3:0] : trial[3:0];
                    bit_next          = 4'd0;
                    rem_next          = 4'd0;
                    if (ax_reg == 2'd0)
                    begin
                        idxi_next = ADDR_W'({dq_reg[10:0], ge});
                        idxc_next = 24'(cc_reg);
                        pad_next  = 1'b0;
                    end
                    else
                    begin
                        ax_next = ax_reg - 2'd1;
                    end
                end
            end
            ST_AXIS:
            begin
                idxc_next = idxc_new;
                idxi_next = idxi_new;
                pad_next  = pad_new;
                ax_next   = ax_reg + 2'd1;
                if (ax_reg == last_ax)
                begin
                    ax_next   = 2'd0;
                    ram_raddr = idxi_new;
                    if (pad_new)
                    begin
                        res_valid_next = 1'b1;
                        res_data_next  = 32'd0;
                        res_im_next    = 16'd0;
                        res_col_next   = idxc_new;
                        res_pad_next   = 1'b1;
                        res_done_next  = walk_end;
                        opos_next      = walk_end ? '0 : opos_adv;
                        if (walk_end)
                        begin
                            cc_next = 12'd0;
                        end
                        else if (walk_last)
                        begin
                            cc_next = cc_reg + 12'd1;
                        end
                    end
                    else
                    begin
                        ram_re = 1'b1;
                    end
                end
            end
            ST_MEM:
            begin
                res_valid_next = 1'b1;
                if (op_reg == OP_READ)
                begin
                    res_data_next = 32'(ram_rdata);
                    res_im_next   = 16'(addr_reg);
                    res_col_next  = 24'd0;
                    res_pad_next  = 1'b0;
                    res_done_next = 1'b0;
                end
                else
                begin
                    if (cfg.mode_im2col)
                    begin
                        res_data_next = 32'(ram_rdata);
                    end
                    else
                    begin
                        ram_we        = 1'b1;
                        ram_waddr     = idxi_reg;
                        ram_wdata     = word_sum;
                        res_data_next = 32'(word_sum);
                    end
                    res_im_next   = 16'(idxi_reg);
                    res_col_next  = idxc_reg;
                    res_pad_next  = 1'b0;
                    res_done_next = walk_end;
                    opos_next     = walk_end ? '0 : opos_adv;
                    if (walk_end)
                    begin
                        cc_next = 12'd0;
                    end
                    else if (walk_last)
                    begin
                        cc_next = cc_reg + 12'd1;
                    end
                end
            end
            default:
            begin
                res_valid_next = res_valid_reg && !rsp.ready;
            end
        endcase
    end

    // Control state and walk counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cc_reg        <= 12'd0;
            opos_reg      <= '0;
            koff_reg      <= '0;
            ax_reg        <= 2'd0;
            bit_reg       <= 4'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cc_reg        <= cc_next;
            opos_reg      <= opos_next;
            koff_reg      <= koff_next;
            ax_reg        <= ax_next;
            bit_reg       <= bit_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        data_reg     <= data_next;
        rem_reg      <= rem_next;
        dq_reg       <= dq_next;
        idxc_reg     <= idxc_next;
        idxi_reg     <= idxi_next;
        pad_reg      <= pad_next;
        res_data_reg <= res_data_next;
        res_im_reg   <= res_im_next;
        res_col_reg  <= res_col_next;
        res_pad_reg  <= res_pad_next;
        res_done_reg <= res_done_next;
    end

    assign rsp.valid        = res_valid_reg;
    assign rsp.out_data     = res_data_reg;
    assign rsp.image_index  = res_im_reg;
    assign rsp.column_index = res_col_reg;
    assign rsp.in_padding   = res_pad_reg;
    assign rsp.walk_done    = res_done_reg;
endmodule

// ===== hw/rtl/im2col_col2im_address_engine.sv =====
// A step divides the channel counter by the kernel extent of each active axis in turn in the
// shared remainder unit (ST_DIV), then forms the indexes axis by axis (ST_AXIS), then accesses
// the store (ST_MEM); a position that falls in padding skips the memory state. The back end
// runs one transaction at a time; a two-entry command queue lets new transactions arrive while
// one executes. Reset clears the walk counters and loads the register defaults; the image store
// is undefined until written.
module im2col_col2im_address_engine #(
    parameter int IMAGE_DEPTH = 65536,
    parameter int MAX_AXES    = 3,
    parameter int DATA_WIDTH  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    ime_cmd_if.sink     cmd,
    ime_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import ime_pkg::*;

    ime_cfg_t  cfg_reg;
    logic      q_valid;
    ime_item_t q_item;
    logic      q_pop;
    logic      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_im2col     <= 1'b1;
            cfg_reg.axis_count      <= 2'd2;
            cfg_reg.column_channels <= 12'd1;
            cfg_reg.geometry        <= {NUM_GEO{GEO_RESET}};
        end
        else if (wr_en)
        begin
            unique case (paddr[5:3])
                REG_MODE:     cfg_reg.mode_im2col     <= pwdata[0];
                REG_AXES:     cfg_reg.axis_count      <= pwdata[1:0];
                REG_CHANNELS: cfg_reg.column_channels <= pwdata[11:0];
                REG_GEO0:     cfg_reg.geometry[0]     <= pwdata[39:0];
                REG_GEO1:     cfg_reg.geometry[1]     <= pwdata[39:0];
                REG_GEO2:     cfg_reg.geometry[2]     <= pwdata[39:0];
                default:      cfg_reg.mode_im2col     <= cfg_reg.mode_im2col;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (paddr[5:3])
            REG_MODE:     prdata = 64'(cfg_reg.mode_im2col);
            REG_AXES:     prdata = 64'(cfg_reg.axis_count);
            REG_CHANNELS: prdata = 64'(cfg_reg.column_channels);
            REG_GEO0:     prdata = 64'(cfg_reg.geometry[0]);
            REG_GEO1:     prdata = 64'(cfg_reg.geometry[1]);
            REG_GEO2:     prdata = 64'(cfg_reg.geometry[2]);
            default:      prdata = 64'd0;
        endcase
    end

    ime_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    ime_back #(
        .IMAGE_DEPTH (IMAGE_DEPTH),
        .MAX_AXES    (MAX_AXES),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );
endmodule

// ===== test/im2col_col2im_address_engine_tb.sv =====
`timescale 1ns / 1ps

module im2col_col2im_address_engine_tb;
    import ime_pkg::*;

    // Per-transaction fields seen on the response channel.
    typedef struct {
        logic [31:0] data;
        logic [15:0] img;
        logic [23:0] col;
        logic        pad;
        logic        done;
    } walk_result_t;

    // Commands issued in each random phase.
    localparam int PHASE_ITEMS = 30;

    logic clk;
    logic rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    ime_cmd_if cmd ();
    ime_rsp_if rsp ();

    im2col_col2im_address_engine DUT (
        .clk(clk), .rst_n(rst_n), .cmd(cmd.sink), .rsp(rsp.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state: store image, walk counters and register copies.
    logic [31:0] image_mem [0:65535];
    int unsigned chan_pos;
    int unsigned out_pos [3];
    logic        cfg_gather;
    logic [1:0]  cfg_axes;
    logic [11:0] cfg_chans;
    logic [39:0] cfg_geo [3];

    ime_item_t     pending_cmds [$];
    walk_result_t  expected_results [$];
    int            errors;
    int            idle_cycles;
    int            rsp_hold;
    int            long_hold;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned at_least_one(int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic int unsigned geo_field(int a, int sh, int w);
        return 32'((cfg_geo[a] >> sh) & ((40'd1 << w) - 40'd1));
    endfunction

    // Computes the expected response for one command and updates the walk state.
    function automatic walk_result_t predict_walk(ime_item_t it);
        walk_result_t r;
        int n;
        int d;
        int unsigned chans;
        int unsigned cc;
        int unsigned kext [3];
        int unsigned oext [3];
        int unsigned iext [3];
        int unsigned koff [3];
        longint unsigned ksize;
        longint unsigned rem;
        longint unsigned idx_col;
        longint unsigned idx_im;
        longint pos;
        bit last;
        r = '{default: '0};
        case (it.op)
            OP_WRITE:
            begin
                image_mem[it.addr] = it.data;
                r.data = it.data;
                r.img = it.addr;
            end
            OP_READ:
            begin
                r.data = image_mem[it.addr];
                r.img = it.addr;
            end
            OP_RESTART:
            begin
                chan_pos = 0;
                out_pos = '{0, 0, 0};
            end
            default:
            begin
                n = int'(at_least_one(32'(cfg_axes)));
                chans = at_least_one(32'(cfg_chans));
                cc = chan_pos;
                ksize = 1;
                for (d = 0; d < n; d++)
                begin
                    iext[d] = geo_field(d, 0, 12);
                    oext[d] = at_least_one(geo_field(d, 12, 12));
                    kext[d] = at_least_one(geo_field(d, 24, 4));
                    ksize *= kext[d];
                end
                rem = cc;
                for (d = n - 1; d >= 0; d--)
                begin
                    if (d < n - 1)
                        rem /= kext[d + 1];
                    koff[d] = 32'(rem % kext[d]);
                end
                idx_col = cc;
                idx_im = cc / ksize;
                for (d = 0; d < n; d++)
                begin
                    pos = longint'(out_pos[d]) * geo_field(d, 32, 4) - geo_field(d, 28, 4)
                        + longint'(koff[d]) * geo_field(d, 36, 4);
                    if (pos < 0 || pos >= longint'(iext[d]))
                        r.pad = 1'b1;
                    idx_col = idx_col * oext[d] + out_pos[d];
                    idx_im = idx_im * iext[d] + (r.pad ? 64'd0 : 64'(pos));
                end
                r.col = idx_col[23:0];
                if (!r.pad)
                begin
                    r.img = idx_im[15:0];
                    if (!cfg_gather)
                        image_mem[r.img] = image_mem[r.img] + it.data;
                    r.data = image_mem[r.img];
                end
                last = 1'b1;
                for (d = n - 1; d >= 0; d--)
                begin
                    if (out_pos[d] >= oext[d] - 1)
                        out_pos[d] = 0;
                    else
                    begin
                        out_pos[d]++;
                        last = 1'b0;
                        break;
                    end
                end
                if (last)
                begin
                    if (cc >= chans - 1)
                    begin
                        r.done = 1'b1;
                        chan_pos = 0;
                        out_pos = '{0, 0, 0};
                    end
                    else
                        chan_pos = cc + 1;
                end
            end
        endcase
        return r;
    endfunction

    // Driver: presents queued commands with a random gap after each one.
    int cmd_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd.valid <= 1'b0;
            cmd.opcode <= '0;
            cmd.address <= '0;
            cmd.data_in <= '0;
            cmd_gap <= 0;
        end
        else if (!cmd.valid || cmd.ready)
        begin
            if (cmd.valid && cmd.ready)
                expected_results.insert(expected_results.size(),
                                        predict_walk(pending_cmds.pop_front()));
            if (cmd_gap > 0 || pending_cmds.size() == 0)
            begin
                cmd.valid <= 1'b0;
                if (cmd_gap > 0)
                    cmd_gap <= cmd_gap - 1;
            end
            else
            begin
                cmd.valid <= 1'b1;
                cmd.opcode <= pending_cmds[0].op;
                cmd.address <= pending_cmds[0].addr;
                cmd.data_in <= pending_cmds[0].data;
                cmd_gap <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 12));
            end
        end
    end

    // Monitor: checks each response transaction and paces the ready line.
    always @(posedge clk or negedge rst_n)
    begin
        walk_result_t e;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rsp_hold <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            if ((rsp.valid && rsp.ready) || (cmd.valid && cmd.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected response transaction");
                    errors++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (rsp.out_data !== e.data)
                    begin
                        $error("out_data: expected %h, got %h", e.data, rsp.out_data);
                        errors++;
                    end
                    if (rsp.image_index !== e.img)
                    begin
                        $error("image_index: expected %h, got %h", e.img, rsp.image_index);
                        errors++;
                    end
                    if (rsp.column_index !== e.col)
                    begin
                        $error("column_index: expected %h, got %h", e.col, rsp.column_index);
                        errors++;
                    end
                    if (rsp.in_padding !== e.pad)
                    begin
                        $error("in_padding: expected %b, got %b", e.pad, rsp.in_padding);
                        errors++;
                    end
                    if (rsp.walk_done !== e.done)
                    begin
                        $error("walk_done: expected %b, got %b", e.done, rsp.walk_done);
                        errors++;
                    end
                end
            end
            // A long hold-off lets the command queue fill and push back.
            if (long_hold > 0)
            begin
                rsp.ready <= 1'b0;
                long_hold <= long_hold - 1;
            end
            else if (rsp_hold > 0)
            begin
                rsp.ready <= 1'b0;
                rsp_hold <= rsp_hold - 1;
            end
            else if (rsp.valid && rsp.ready || !rsp.ready)
            begin
                if (!rsp.ready && !(rsp.valid && rsp.ready))
                    rsp.ready <= 1'b1;
                else if ($urandom_range(0, 2) == 0)
                begin
                    rsp.ready <= 1'b0;
                    rsp_hold <= int'($urandom_range(0, 12));
                end
            end
            if (idle_cycles > 20000)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Single APB register write: setup then access phase.
    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MODE:     cfg_gather = value[0];
            REG_AXES:     cfg_axes = value[1:0];
            REG_CHANNELS: cfg_chans = value[11:0];
            REG_GEO0:     cfg_geo[0] = value[39:0];
            REG_GEO1:     cfg_geo[1] = value[39:0];
            default:      cfg_geo[2] = value[39:0];
        endcase
    endtask

    task automatic queue_cmd(ime_op_t op, logic [15:0] addr, logic [31:0] data);
        ime_item_t it;
        it.op = op;
        it.addr = addr;
        it.data = data;
        pending_cmds.insert(pending_cmds.size(), it);
    endtask

    // Waits for all outstanding responses, then lets the pipeline drain.
    task automatic wait_quiet();
        while (pending_cmds.size() != 0 || cmd.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [39:0] pack_geo(int unsigned iext, int unsigned oext,
                                             int unsigned k, int unsigned p,
                                             int unsigned s, int unsigned dil);
        return {dil[3:0], s[3:0], p[3:0], k[3:0], oext[11:0], iext[11:0]};
    endfunction

    // Fills the image region a walk can touch, so no unwritten word is read.
    task automatic load_image(int unsigned words, bit zero);
        for (int unsigned a = 0; a < words; a++)
            queue_cmd(OP_WRITE, a[15:0], zero ? 32'd0 : $urandom());
    endtask

    // Words a walk can reach: the channel counter stays below the larger of the channel
    // count and chan_floor, and within one phase it climbs by at most one per command.
    function automatic int unsigned image_words(int unsigned chan_floor);
        int n;
        longint unsigned w;
        n = int'(at_least_one(32'(cfg_axes)));
        if (n > 3)
            n = 3;
        w = at_least_one(32'(cfg_chans));
        if (w > PHASE_ITEMS + 4)
            w = PHASE_ITEMS + 4;
        if (w < chan_floor)
            w = chan_floor;
        for (int d = 0; d < n; d++)
            w *= geo_field(d, 0, 12);
        return (w > 65536) ? 65536 : 32'(w);
    endfunction

    initial
    begin
        int steps;
        int phase;
        logic [39:0] g;
        errors = 0;
        long_hold = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd.valid = 1'b0;
        cmd.opcode = '0;
        cmd.address = '0;
        cmd.data_in = '0;
        rsp.ready = 1'b0;
        cfg_gather = 1'b1;
        cfg_axes = 2'd2;
        cfg_chans = 12'd1;
        cfg_geo = '{GEO_RESET, GEO_RESET, GEO_RESET};
        chan_pos = 0;
        out_pos = '{0, 0, 0};
        for (int a = 0; a < 65536; a++)
            image_mem[a] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes of the store and data, every operation, reset geometry.
        queue_cmd(OP_WRITE, 16'hFFFF, 32'h7FFF_FFFF);
        queue_cmd(OP_WRITE, 16'h0000, 32'h8000_0000);
        queue_cmd(OP_WRITE, 16'h0001, 32'hFFFF_FFFF);
        queue_cmd(OP_READ, 16'hFFFF, 32'hFFFF_FFFF);
        queue_cmd(OP_READ, 16'h0000, 32'h0);
        queue_cmd(OP_STEP, 16'hAAAA, 32'h5555_5555);
        queue_cmd(OP_STEP, 16'h5555, 32'h0);
        queue_cmd(OP_RESTART, 16'hFFFF, 32'hFFFF_FFFF);
        queue_cmd(OP_STEP, 16'h0, 32'h0);
        wait_quiet();

        // Directed: zero axis count, zero extents and zero image (all padding).
        write_reg(REG_AXES, 64'd0);
        write_reg(REG_CHANNELS, 64'd0);
        write_reg(REG_GEO0, 64'd0);
        write_reg(REG_GEO1, 64'({40{1'b1}}));
        write_reg(REG_GEO2, 64'({40{1'b1}}));
        queue_cmd(OP_STEP, 16'h0, 32'h1);
        queue_cmd(OP_STEP, 16'h0, 32'h1);
        wait_quiet();

        // Directed: three axes with padding, scatter mode, 32-bit wrap checks.
        write_reg(REG_MODE, 64'd0);
        write_reg(REG_AXES, 64'd3);
        write_reg(REG_CHANNELS, 64'd2);
        write_reg(REG_GEO0, 64'(pack_geo(2, 2, 2, 1, 1, 1)));
        write_reg(REG_GEO1, 64'(pack_geo(2, 1, 1, 0, 1, 1)));
        write_reg(REG_GEO2, 64'(pack_geo(3, 2, 2, 0, 2, 15)));
        load_image(image_words(1), 1'b0);
        for (int i = 0; i < 10; i++)
            queue_cmd(OP_STEP, 16'h0, (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0001);
        wait_quiet();

        // Backpressure: hold the response side while commands keep coming.
        long_hold = 300;
        for (int i = 0; i < 12; i++)
            queue_cmd(OP_READ, 16'($urandom_range(0, 7)), 32'h0);
        wait_quiet();

        // Random phases of configuration, preload and walk.
        steps = 0;
        phase = 0;
        while (steps < 8 * PHASE_ITEMS)
        begin
            write_reg(REG_MODE, 64'($urandom_range(0, 1)));
            write_reg(REG_AXES, (phase == 3) ? 64'd1 : 64'($urandom_range(0, 3)));
            write_reg(REG_CHANNELS, (phase == 3) ? 64'd4095 : 64'($urandom_range(0, 4)));
            for (int d = 0; d < 3; d++)
            begin
                g = pack_geo($urandom_range(0, 2), $urandom_range(0, 3), $urandom_range(0, 3),
                             $urandom_range(0, 2), $urandom_range(0, 3), $urandom_range(0, 2));
                // Widest fields everywhere, with an empty first axis so every step pads.
                if (phase == 5)
                    g = (d == 0) ? {28'hFFF_FFFF, 12'd0} : {40{1'b1}};
                write_reg(3'(REG_GEO0 + d), 64'(g));
            end
            // The wide channel phase leaves the counter high, so start the next walk over.
            if (phase == 4)
                queue_cmd(OP_RESTART, 16'h0, 32'h0);
            load_image(image_words(4), 1'($urandom_range(0, 1)));
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                case ($urandom_range(0, 9))
                    0: queue_cmd(OP_READ, 16'($urandom_range(0, 15)), $urandom());
                    1: queue_cmd(OP_RESTART, 16'($urandom()), $urandom());
                    2: queue_cmd(OP_WRITE, 16'($urandom_range(0, 15)), $urandom());
                    default: queue_cmd(OP_STEP, 16'($urandom()), $urandom());
                endcase
                steps++;
            end
            wait_quiet();
            phase++;
        end

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/ime_pkg.sv
hw/rtl/ime_cmd_if.sv
hw/rtl/ime_rsp_if.sv
hw/rtl/ime_ram.sv
hw/rtl/ime_front.sv
hw/rtl/ime_back.sv
hw/rtl/im2col_col2im_address_engine.sv
test/im2col_col2im_address_engine_tb.sv
